// File: sv/pnfe_pkg.sv
package pnfe_pkg;
  localparam int PLACES_DEF = 8;
  localparam int TRANSITIONS_DEF = 8;
  localparam int WEIGHT_BITS_DEF = 4;
  localparam int TOKEN_BITS_DEF = 16;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_MARK = 2'd1;
  localparam logic [1:0] KIND_NAMED = 2'd2;
  localparam logic [1:0] KIND_PICK = 2'd3;

  localparam logic [2:0] ST_FIRED = 3'd0;
  localparam logic [2:0] ST_LOADED = 3'd1;
  localparam logic [2:0] ST_NOT_EN = 3'd2;
  localparam logic [2:0] ST_DEADLOCK = 3'd3;
  localparam logic [2:0] ST_BUDGET = 3'd4;

  localparam logic CFG_RUN_LIMIT = 1'b0;
  localparam logic CFG_RUN_UNLIMITED = 1'b1;

  typedef struct packed {
    logic start;      // latch request, clear scratch
    logic do_write;   // apply arc load or marking set
    logic scan_step;  // evaluate one transition against all places
    logic mod_step;   // one restoring step of pick modulo count
    logic sel_step;   // one transition of the pick selection
    logic fire_step;  // update one place
    logic fire_done;  // bump firing count
    logic rescan_clr; // clear enabled mask before rescan
  } pnfe_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic mod_last;
    logic sel_last;
    logic fire_last;
    logic none_en;
    logic budget_out;
    logic named_ok;
  } pnfe_sts_t;
endpackage

// File: sv/pnfe_ctrl.sv
module pnfe_ctrl
  import pnfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [1:0] kind,
  input  logic       out_free,
  input  pnfe_sts_t  sts,
  output pnfe_cmd_t  cmd,
  output logic [2:0] status,
  output logic       idle,
  output logic       done
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_DEC = 4'd2, S_MOD = 4'd3,
    S_SEL = 4'd4, S_FIRE = 4'd5, S_RCLR = 4'd6, S_RSCAN = 4'd7, S_OUT = 4'd8,
    S_WR = 4'd9;
  logic [3:0] state_r, state_nxt;
  logic [2:0] status_r, status_nxt;
  logic [1:0] kind_r, kind_nxt;

  always_comb begin
    state_nxt = state_r;
    status_nxt = status_r;
    kind_nxt = kind_r;
    cmd = '0;
    done = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.start = 1'b1;
        kind_nxt = kind;
        state_nxt = (kind == KIND_LOAD || kind == KIND_MARK) ? S_WR : S_SCAN;
      end
      S_WR: begin
        cmd.do_write = 1'b1;
        status_nxt = ST_LOADED;
        state_nxt = S_RCLR;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (sts.budget_out) begin
          status_nxt = ST_BUDGET; state_nxt = S_RCLR;
        end else if (sts.none_en) begin
          status_nxt = ST_DEADLOCK; state_nxt = S_RCLR;
        end else if (kind_r == KIND_NAMED) begin
          status_nxt = sts.named_ok ? ST_FIRED : ST_NOT_EN;
          state_nxt = sts.named_ok ? S_FIRE : S_RCLR;
        end else begin
          status_nxt = ST_FIRED; state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_nxt = S_SEL;
      end
      S_SEL: begin
        cmd.sel_step = 1'b1;
        if (sts.sel_last) state_nxt = S_FIRE;
      end
      S_FIRE: begin
        cmd.fire_step = 1'b1;
        if (sts.fire_last) begin
          cmd.fire_done = 1'b1; state_nxt = S_RCLR;
        end
      end
      S_RCLR: begin
        cmd.rescan_clr = 1'b1; state_nxt = S_RSCAN;
      end
      S_RSCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_OUT;
      end
      S_OUT: if (out_free) begin
        done = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      status_r <= ST_LOADED;
      kind_r <= KIND_LOAD;
    end else begin
      state_r <= state_nxt;
      status_r <= status_nxt;
      kind_r <= kind_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);
  assign status = status_r;
endmodule

// File: sv/pnfe_dp.sv
module pnfe_dp
  import pnfe_pkg::*;
#(
  parameter int PLACES = PLACES_DEF,
  parameter int TRANSITIONS = TRANSITIONS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pnfe_cmd_t   cmd,
  input  logic [2:0]  in_transition,
  input  logic [2:0]  in_place,
  input  logic [3:0]  in_pre,
  input  logic [3:0]  in_post,
  input  logic [15:0] in_tokens,
  input  logic [15:0] in_pick,
  input  logic [1:0]  in_kind,
  input  logic [15:0] run_limit,
  input  logic        run_unlimited,
  output pnfe_sts_t   sts,
  output logic [2:0]  fired,
  output logic [7:0]  en_mask,
  output logic [15:0] place_tok,
  output logic [15:0] fire_cnt,
  output logic        sat
);
  localparam int PB = (PLACES > 1) ? $clog2(PLACES) : 1;
  localparam int TB = (TRANSITIONS > 1) ? $clog2(TRANSITIONS) : 1;
  localparam int CB = $clog2(TRANSITIONS + 1);
  localparam logic [WEIGHT_BITS-1:0] WMAX = '1;
  localparam logic [TOKEN_BITS-1:0] TMAX = '1;

  // arc weights, one row per transition with one weight per place, cleared by reset
  logic [PLACES*WEIGHT_BITS-1:0] pre_r [TRANSITIONS];
  logic [PLACES*WEIGHT_BITS-1:0] post_r [TRANSITIONS];
  logic [TOKEN_BITS-1:0] mark_r [PLACES];
  logic [15:0] fire_cnt_r;
  logic [TRANSITIONS-1:0] en_r;
  logic [CB-1:0] cnt_r;
  logic [TB-1:0] t_r;
  logic [PB-1:0] p_r;
  logic [4:0] mbit_r;
  logic [15:0] rem_r;
  logic [CB-1:0] seen_r;
  logic [TB-1:0] tsel_r;
  logic found_r, sat_r;
  logic [2:0] tr_r, pl_r;
  logic [15:0] pick_r;

  logic t_ok;
  logic [TOKEN_BITS:0] fsum;
  logic [TOKEN_BITS-1:0] mp;
  logic [16:0] rtry;

  always_comb begin
    t_ok = 1'b1;
    for (int p = 0; p < PLACES; p++)
      if (mark_r[p] < TOKEN_BITS'(pre_r[t_r][p*WEIGHT_BITS +: WEIGHT_BITS])) t_ok = 1'b0;
  end
  assign mp = mark_r[p_r];
  assign fsum = {1'b0, mp}
              - (TOKEN_BITS+1)'(pre_r[tsel_r][32'(p_r)*WEIGHT_BITS +: WEIGHT_BITS])
              + (TOKEN_BITS+1)'(post_r[tsel_r][32'(p_r)*WEIGHT_BITS +: WEIGHT_BITS]);
  assign rtry = {rem_r[14:0], pick_r[mbit_r[3:0]]} - 17'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PLACES; p++) mark_r[p] <= '0;
      for (int t = 0; t < TRANSITIONS; t++) begin
        pre_r[t] <= '0;
        post_r[t] <= '0;
      end
      fire_cnt_r <= '0;
      en_r <= '0;
      cnt_r <= '0; t_r <= '0; p_r <= '0; mbit_r <= '0; rem_r <= '0;
      seen_r <= '0; tsel_r <= '0; found_r <= 1'b0; sat_r <= 1'b0;
      tr_r <= '0; pl_r <= '0; pick_r <= '0;
    end else begin
      if (cmd.start) begin
        tr_r <= in_transition; pl_r <= in_place; pick_r <= in_pick;
        en_r <= '0; cnt_r <= '0; t_r <= '0; p_r <= '0; sat_r <= 1'b0;
        mbit_r <= 5'd15; rem_r <= '0; seen_r <= '0; found_r <= 1'b0;
        tsel_r <= TB'(in_transition);
      end
      if (cmd.do_write) begin
        if (in_kind == KIND_LOAD) begin
          if (32'(pl_r) < PLACES && 32'(tr_r) < TRANSITIONS) begin
            pre_r[TB'(tr_r)][32'(pl_r)*WEIGHT_BITS +: WEIGHT_BITS] <=
              (32'(in_pre) > 32'(WMAX)) ? WMAX : WEIGHT_BITS'(in_pre);
            post_r[TB'(tr_r)][32'(pl_r)*WEIGHT_BITS +: WEIGHT_BITS] <=
              (32'(in_post) > 32'(WMAX)) ? WMAX : WEIGHT_BITS'(in_post);
          end
        end else if (32'(pl_r) < PLACES) begin
          if (33'(in_tokens) > 33'(TMAX)) begin
            mark_r[PB'(pl_r)] <= TMAX; sat_r <= 1'b1;
          end else mark_r[PB'(pl_r)] <= TOKEN_BITS'(in_tokens);
        end
      end
      if (cmd.scan_step) begin
        en_r[t_r] <= t_ok;
        cnt_r <= cnt_r + CB'(t_ok);
        t_r <= (32'(t_r) == TRANSITIONS - 1) ? '0 : t_r + 1'b1;
      end
      if (cmd.rescan_clr) begin
        en_r <= '0; cnt_r <= '0; t_r <= '0;
      end
      if (cmd.mod_step) begin
        rem_r <= rtry[16] ? {rem_r[14:0], pick_r[mbit_r[3:0]]} : rtry[15:0];
        mbit_r <= mbit_r - 1'b1;
      end
      if (cmd.sel_step) begin
        if (!found_r && en_r[t_r]) begin
          if (16'(seen_r) == rem_r) begin
            found_r <= 1'b1; tsel_r <= t_r;
          end
          seen_r <= seen_r + 1'b1;
        end
        t_r <= (32'(t_r) == TRANSITIONS - 1) ? '0 : t_r + 1'b1;
      end
      if (cmd.fire_step) begin
        if (fsum > (TOKEN_BITS+1)'(TMAX)) begin
          mark_r[p_r] <= TMAX; sat_r <= 1'b1;
        end else mark_r[p_r] <= fsum[TOKEN_BITS-1:0];
        p_r <= (32'(p_r) == PLACES - 1) ? '0 : p_r + 1'b1;
      end
      if (cmd.fire_done) begin
        if (fire_cnt_r != 16'hFFFF) fire_cnt_r <= fire_cnt_r + 1'b1;
        found_r <= 1'b1;
      end
    end
  end

  assign sts.scan_last = (32'(t_r) == TRANSITIONS - 1);
  assign sts.mod_last = (mbit_r == 5'd0);
  assign sts.sel_last = (32'(t_r) == TRANSITIONS - 1);
  assign sts.fire_last = (32'(p_r) == PLACES - 1);
  assign sts.none_en = (en_r == '0);
  assign sts.budget_out = !run_unlimited && (fire_cnt_r >= run_limit);
  assign sts.named_ok = (32'(tr_r) < TRANSITIONS) && en_r[TB'(tr_r)];

  always_comb begin
    en_mask = '0;
    for (int t = 0; t < TRANSITIONS && t < 8; t++) en_mask[t] = en_r[t];
  end
  // fired index valid only once a firing completed
  assign fired = found_r ? 3'(tsel_r) : 3'd0;
  assign place_tok = (32'(pl_r) < PLACES) ? 16'(mark_r[PB'(pl_r)]) : 16'd0;
  assign fire_cnt = fire_cnt_r;
  assign sat = sat_r;
endmodule

// File: sv/petri_net_firing_engine_core.sv
// Channel | Dir | Contents
// in_     | in  | one request: arc load, marking set, named fire or pick fire
// out_    | out | one result per request
// cfg_    | in  | run_limit (index 0), run_unlimited (index 1)
// A load or marking request is followed by a rescan of enables.
// A fire scans enables, fires and rescans; pick fires add a modulo and a selection pass:
// the enable scan checks one transition per cycle and pick modulo is bit serial.
// rst_n is synchronous; it clears arcs, markings and firing count and resets config.
// One request at a time; the result holds in out_tdata until out_tready.
module petri_net_firing_engine_core
  import pnfe_pkg::*;
#(
  parameter int PLACES = PLACES_DEF,
  parameter int TRANSITIONS = TRANSITIONS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // transition[2:0], place[5:3], pre_weight[9:6], post_weight[13:10],
  // tokens[29:14], pick[45:30], zero[47:46]
  input  logic [47:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], fired_transition[5:3], enabled_mask[13:6], place_tokens[29:14],
  // firing_count[45:30], saturated[46], zero[47]
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  pnfe_cmd_t cmd;
  pnfe_sts_t sts;
  logic idle, done, out_vld_r;
  logic [2:0] status, fired;
  logic [7:0] en_mask;
  logic [15:0] place_tok, fire_cnt;
  logic sat;
  logic [15:0] run_limit_r;
  logic run_unl_r;
  logic [45:0] in_hold_r;
  logic [1:0] kind_hold_r;
  logic in_fire;

  assign in_fire = in_tvalid && in_tready;
  assign in_tready = idle && !out_vld_r;

  // hold the request payload for the datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_hold_r <= in_tdata[45:0];
      kind_hold_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_limit_r <= '0; run_unl_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RUN_LIMIT: run_limit_r <= cfg_wdata;
        CFG_RUN_UNLIMITED: run_unl_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  pnfe_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .kind(in_tuser),
    .out_free(!out_vld_r), .sts(sts), .cmd(cmd), .status(status),
    .idle(idle), .done(done)
  );

  pnfe_dp #(.PLACES(PLACES), .TRANSITIONS(TRANSITIONS),
    .WEIGHT_BITS(WEIGHT_BITS), .TOKEN_BITS(TOKEN_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_transition(cmd.start ? in_tdata[2:0] : in_hold_r[2:0]),
    .in_place(cmd.start ? in_tdata[5:3] : in_hold_r[5:3]),
    .in_pre(in_hold_r[9:6]), .in_post(in_hold_r[13:10]),
    .in_tokens(in_hold_r[29:14]),
    .in_pick(cmd.start ? in_tdata[45:30] : in_hold_r[45:30]),
    .in_kind(kind_hold_r), .run_limit(run_limit_r), .run_unlimited(run_unl_r),
    .sts(sts), .fired(fired), .en_mask(en_mask), .place_tok(place_tok),
    .fire_cnt(fire_cnt), .sat(sat)
  );

  // output register parts the result from the engine
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (done) out_vld_r <= 1'b1;
    else if (out_tready) out_vld_r <= 1'b0;
  end
  always_ff @(posedge clk)
    if (done) out_tdata <= {1'b0, sat, fire_cnt, place_tok, en_mask, fired, status};
  assign out_tvalid = out_vld_r;

  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("request accepted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_tvalid) else $error("result lost");
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready) else $error("accept with full output");
endmodule

// File: verif/petri_net_firing_engine_core_test.sv
module petri_net_firing_engine_core_test;
  import pnfe_pkg::*;

  localparam int NP = 8;
  localparam int NT = 8;
  localparam int LIMIT_CYCLES = 900000;

  typedef struct packed {
    logic [15:0] pick;
    logic [15:0] tokens;
    logic [3:0]  post_weight;
    logic [3:0]  pre_weight;
    logic [2:0]  place;
    logic [2:0]  transition;
    logic [1:0]  kind;
  } net_req_t;

  typedef struct packed {
    logic        zero;
    logic        saturated;
    logic [15:0] firing_count;
    logic [15:0] place_tokens;
    logic [7:0]  enabled_mask;
    logic [2:0]  fired_transition;
    logic [2:0]  status;
  } net_res_t;

  // Stimulus table row: request, plus an optional typed-in result
  typedef struct {
    net_req_t req;
    bit       has_res;
    net_res_t res;
  } net_row_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [15:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  petri_net_firing_engine_core dut (.*);

  // Shadow copy of the net
  logic [3:0]  pre_w [NP][NT];
  logic [3:0]  post_w[NP][NT];
  logic [15:0] tok_of[NP];
  logic [15:0] fire_cnt;
  logic [15:0] lim_reg;
  logic        unlim_reg;

  net_res_t result_q[$];
  int errors = 0;
  int sent = 0, got = 0, fired_seen = 0, dead_seen = 0, budget_seen = 0;
  int cycles = 0;
  bit rx_stall_mode = 0;

  function automatic logic [7:0] enabled_now();
    logic [7:0] m;
    m = '0;
    for (int t = 0; t < NT; t++) begin
      m[t] = 1'b1;
      for (int p = 0; p < NP; p++)
        if (tok_of[p] < pre_w[p][t]) m[t] = 1'b0;
    end
    return m;
  endfunction

  function automatic logic fire_transition(int t);
    logic clip;
    int v;
    clip = 0;
    for (int p = 0; p < NP; p++) begin
      v = int'(tok_of[p]) - int'(pre_w[p][t]) + int'(post_w[p][t]);
      if (v > 65535) begin
        v = 65535;
        clip = 1;
      end
      tok_of[p] = v[15:0];
    end
    if (fire_cnt != 16'hFFFF) fire_cnt++;
    return clip;
  endfunction

  // Advance the shadow net by one request and return the expected result
  function automatic net_res_t step_net(net_req_t r);
    net_res_t o;
    logic [7:0] en;
    int cnt, target, seen;
    o = '0;
    o.status = ST_LOADED;
    case (r.kind)
      KIND_LOAD: begin
        pre_w[r.place][r.transition] = r.pre_weight;
        post_w[r.place][r.transition] = r.post_weight;
      end
      KIND_MARK: tok_of[r.place] = r.tokens;
      default: begin
        en = enabled_now();
        if (!unlim_reg && fire_cnt >= lim_reg) o.status = ST_BUDGET;
        else if (en == 0) o.status = ST_DEADLOCK;
        else if (r.kind == KIND_NAMED) begin
          if (en[r.transition]) begin
            o.saturated = fire_transition(r.transition);
            o.fired_transition = r.transition;
            o.status = ST_FIRED;
          end else o.status = ST_NOT_EN;
        end else begin
          cnt = $countones(en);
          target = r.pick % cnt;
          seen = 0;
          for (int t = 0; t < NT; t++)
            if (en[t]) begin
              if (seen == target) o.fired_transition = 3'(t);
              seen++;
            end
          o.saturated = fire_transition(o.fired_transition);
          o.status = ST_FIRED;
        end
      end
    endcase
    o.enabled_mask = enabled_now();
    o.place_tokens = tok_of[r.place];
    o.firing_count = fire_cnt;
    return o;
  endfunction

  // Drive one request; hold valid across back-to-back requests
  task automatic send_request(net_req_t r, bit has_res = 0, net_res_t typed = '0);
    net_res_t e;
    e = step_net(r);
    if (has_res && e != typed)
      $display("%0t typed-in result disagrees: expected %h predictor %h",
               $time, typed, e);
    result_q.push_back(has_res ? typed : e);
    in_tuser <= r.kind;
    in_tdata <= {2'b00, r.pick, r.tokens, r.post_weight, r.pre_weight, r.place,
                 r.transition};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent++;
    @(negedge clk);
    // Drop valid only on a random gap
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  endtask

  task automatic idle_sender();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    idle_sender();
    while (result_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RUN_LIMIT) lim_reg = val;
    else unlim_reg = val[0];
  endtask

  function automatic net_req_t mk(logic [1:0] k, int t, int p, int a, int b,
                                  int tk, int pk);
    net_req_t r;
    r.kind = k; r.transition = 3'(t); r.place = 3'(p); r.pre_weight = 4'(a);
    r.post_weight = 4'(b); r.tokens = 16'(tk); r.pick = 16'(pk);
    return r;
  endfunction

  function automatic net_res_t rs(logic [2:0] s, int f, int m, int pt, int fc, int sat);
    net_res_t o;
    o = '0;
    o.status = s; o.fired_transition = 3'(f); o.enabled_mask = 8'(m);
    o.place_tokens = 16'(pt); o.firing_count = 16'(fc); o.saturated = 1'(sat);
    return o;
  endfunction

  // Receiver: stall on its own pattern, check each accepted result
  always @(negedge clk) begin
    if (rx_stall_mode) out_tready <= ($urandom_range(0, 2) != 0);
    else out_tready <= ($urandom_range(0, 15) == 0) || (cycles[6:4] == 3'b101) ? 1'b0 : 1'b1;
  end

  always @(posedge clk) begin
    net_res_t a, e;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      a = out_tdata;
      got++;
      if (result_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, a);
        errors++;
      end else begin
        e = result_q.pop_front();
        if (a.status == ST_FIRED) fired_seen++;
        if (a.status == ST_DEADLOCK) dead_seen++;
        if (a.status == ST_BUDGET) budget_seen++;
        if (a.status !== e.status || a.fired_transition !== e.fired_transition ||
            a.enabled_mask !== e.enabled_mask || a.place_tokens !== e.place_tokens ||
            a.firing_count !== e.firing_count || a.saturated !== e.saturated ||
            a.zero !== 1'b0) begin
          $display("%0t result mismatch: expected %h actual %h", $time, e, a);
          errors++;
        end
      end
    end
    if (cycles >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Random net traffic: arc loads, markings, named fires and pick fires in random mix
  task automatic random_phase(int n);
    net_req_t r;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      r = mk(KIND_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
             $urandom_range(0, 3), $urandom_range(0, 3),
             $urandom_range(0, 20), $urandom);
      if (k < 12) begin
        r.kind = KIND_LOAD;
        if ($urandom_range(0, 7) == 0) begin
          r.pre_weight = 4'($urandom); r.post_weight = 4'($urandom);
        end
      end else if (k < 22) begin
        r.kind = KIND_MARK;
        if ($urandom_range(0, 5) == 0) r.tokens = 16'($urandom);
        if ($urandom_range(0, 9) == 0) r.tokens = 16'hFFFF - 16'($urandom_range(0, 3));
      end else if (k < 50) r.kind = KIND_NAMED;
      else r.kind = KIND_PICK;
      send_request(r);
    end
  endtask

  net_row_t table_rows[$];

  initial begin
    for (int p = 0; p < NP; p++) begin
      tok_of[p] = '0;
      for (int t = 0; t < NT; t++) begin
        pre_w[p][t] = '0; post_w[p][t] = '0;
      end
    end
    fire_cnt = '0; lim_reg = '0; unlim_reg = 1'b1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table: an empty net has every transition enabled
    table_rows.push_back('{mk(KIND_MARK, 0, 7, 0, 0, 16'hFFFF, 0), 1,
                           rs(ST_LOADED, 0, 8'hFF, 16'hFFFF, 0, 0)});
    table_rows.push_back('{mk(KIND_LOAD, 7, 7, 15, 15, 0, 0), 0, '0});
    table_rows.push_back('{mk(KIND_LOAD, 3, 0, 15, 0, 0, 0), 0, '0});
    table_rows.push_back('{mk(KIND_NAMED, 3, 0, 0, 0, 0, 0), 0, '0});
    table_rows.push_back('{mk(KIND_NAMED, 7, 7, 0, 0, 0, 0), 0, '0});
    table_rows.push_back('{mk(KIND_PICK, 0, 7, 0, 0, 0, 16'hFFFF), 0, '0});
    table_rows.push_back('{mk(KIND_PICK, 0, 0, 0, 0, 0, 0), 0, '0});
    table_rows.push_back('{mk(KIND_MARK, 0, 0, 0, 0, 5, 0), 0, '0});
    table_rows.push_back('{mk(KIND_LOAD, 0, 1, 1, 2, 0, 0), 0, '0});
    table_rows.push_back('{mk(KIND_NAMED, 0, 1, 0, 0, 0, 0), 0, '0});
    table_rows.push_back('{mk(KIND_MARK, 5, 1, 15, 15, 16'hAAAA, 16'h5555), 0, '0});
    table_rows.push_back('{mk(KIND_PICK, 7, 6, 15, 15, 16'h5555, 16'hAAAA), 0, '0});
    foreach (table_rows[i])
      send_request(table_rows[i].req, table_rows[i].has_res, table_rows[i].res);
    drain();

    // Block every transition: deadlock on both fire kinds
    for (int t = 0; t < NT; t++)
      send_request(mk(KIND_LOAD, t, 2, 15, 0, 0, 0));
    send_request(mk(KIND_MARK, 0, 2, 0, 0, 0, 0));
    send_request(mk(KIND_NAMED, 1, 2, 0, 0, 0, 0));
    send_request(mk(KIND_PICK, 0, 2, 0, 0, 0, 7));
    send_request(mk(KIND_MARK, 0, 2, 0, 0, 300, 0));
    drain();

    // Budget extremes: zero, then the current count plus 40
    write_cfg(CFG_RUN_LIMIT, 16'd0);
    write_cfg(CFG_RUN_UNLIMITED, 16'd0);
    send_request(mk(KIND_PICK, 0, 0, 0, 0, 0, 3));
    send_request(mk(KIND_NAMED, 0, 0, 0, 0, 0, 0));
    drain();
    write_cfg(CFG_RUN_LIMIT, fire_cnt + 16'd40);
    random_phase(300);
    drain();
    write_cfg(CFG_RUN_LIMIT, 16'hFFFF);
    rx_stall_mode = 1;
    random_phase(450);
    drain();
    write_cfg(CFG_RUN_UNLIMITED, 16'd1);
    rx_stall_mode = 0;
    random_phase(560);
    drain();

    $display("covered %0d requests, %0d results: %0d fired, %0d deadlocks, %0d budget stops",
             sent, got, fired_seen, dead_seen, budget_seen);
    $display("budget settings walked: zero, small, full range and unlimited");
    if (errors == 0 && result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
